// ===== hdl/wbag_pkg.sv =====
// Package for the window border address generator.
// Holds register indexes, edge rule codes, sequencer states and the configuration bundle.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package wbag_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WIN_W      = 3;
    localparam int MODE_W     = 3;
    localparam int INDEX_W    = 6;

    // Register reset values
    localparam logic [WIN_W-1:0]  WIN_X_RST    = 3'd3;
    localparam logic [WIN_W-1:0]  WIN_Y_RST    = 3'd3;
    localparam logic [WIN_W-1:0]  WIN_Z_RST    = 3'd1;
    localparam logic              CENTERED_RST = 1'b1;
    localparam logic [MODE_W-1:0] MODE_RST     = 3'd0;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_X    = 3'd0,
        CFG_WIN_Y    = 3'd1,
        CFG_WIN_Z    = 3'd2,
        CFG_CENTERED = 3'd3,
        CFG_EDGE     = 3'd4,
        CFG_LAST_X   = 3'd5,
        CFG_LAST_Y   = 3'd6,
        CFG_LAST_Z   = 3'd7
    } cfg_reg_t;

    // Edge rules; the spare codes behave as replicate
    typedef enum logic [MODE_W-1:0] {
        EDGE_REPLICATE    = 3'd0,
        EDGE_REFLECT      = 3'd1,
        EDGE_REFLECT_NEXT = 3'd2,
        EDGE_WRAP         = 3'd3,
        EDGE_REJECT       = 3'd4
    } edge_mode_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MAP  = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    // Axis currently fed to the remap unit
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // Window shape and edge rule as held in the register file
    typedef struct packed {
        logic [WIN_W-1:0]  win_x;
        logic [WIN_W-1:0]  win_y;
        logic [WIN_W-1:0]  win_z;
        logic              centered;
        logic [MODE_W-1:0] edge_mode;
    } win_cfg_t;

endpackage

// ===== hdl/wbag_if.sv =====
// Valid/ready channel interfaces for anchor items and cell items.
// Depends on wbag_pkg for the cell index width.
interface wbag_anchor_if #(parameter int COORD_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] anchor_x;
    logic [COORD_BITS-1:0] anchor_y;
    logic [COORD_BITS-1:0] anchor_z;

    modport source (output valid, anchor_x, anchor_y, anchor_z, input ready);
    modport sink   (input valid, anchor_x, anchor_y, anchor_z, output ready);
endinterface

interface wbag_cell_if #(parameter int COORD_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         cell_x;
    logic [COORD_BITS-1:0]         cell_y;
    logic [COORD_BITS-1:0]         cell_z;
    logic [wbag_pkg::INDEX_W-1:0]  cell_index;
    logic                          inside_res;
    logic                          last_cell;

    modport source (output valid, cell_x, cell_y, cell_z, cell_index, inside_res, last_cell,
                    input ready);
    modport sink   (input valid, cell_x, cell_y, cell_z, cell_index, inside_res, last_cell,
                    output ready);
endinterface

// ===== hdl/wbag_axis_map.sv =====
// Shared remap unit: one axis coordinate per cycle, anchor plus offset folded by the edge rule.
// Depends on wbag_pkg for the edge rule codes.
module wbag_axis_map #(
    parameter int COORD_BITS = 16,
    parameter int WIN_BITS   = 3
) (
    input  logic [COORD_BITS-1:0]     anchor,
    input  logic [COORD_BITS-1:0]     last,
    input  logic [WIN_BITS-1:0]       k,
    input  logic [WIN_BITS-1:0]       sub,
    input  logic [wbag_pkg::MODE_W-1:0] mode,
    output logic [COORD_BITS-1:0]     coord,
    output logic                      ok
);
    // One guard bit above twice the raster size, plus sign
    localparam int PW = COORD_BITS + 3;
    localparam logic signed [PW-1:0] ONE = 1;

    logic signed [PW-1:0] p;
    logic signed [PW-1:0] lst;
    logic signed [PW-1:0] lst2;
    logic signed [PW-1:0] q;
    logic signed [PW-1:0] r;
    logic                 below;
    logic                 above;

    always_comb
    begin
        p     = signed'(PW'(anchor)) + signed'(PW'(k)) - signed'(PW'(sub));
        lst   = signed'(PW'(last));
        lst2  = {lst[PW-2:0], 1'b0};
        below = p[PW-1];
        above = p > lst;
        ok    = 1'b1;
        q     = p;

        // Single fold per rule
        case (mode)
            wbag_pkg::EDGE_REFLECT:
            begin
                if (below)
                    q = ~p;
                else if (above)
                    q = lst2 + ONE - p;
            end
            wbag_pkg::EDGE_REFLECT_NEXT:
            begin
                if (below)
                    q = -p;
                else if (above)
                    q = lst2 - p;
            end
            wbag_pkg::EDGE_WRAP:
            begin
                if (below)
                    q = p + lst + ONE;
                else if (above)
                    q = p - lst - ONE;
            end
            wbag_pkg::EDGE_REJECT:
                ok = !(below || above);
            default:
                q = p;
        endcase

        // Final clamp catches folds that overshoot a tiny raster
        if (q[PW-1])
            r = '0;
        else if (q > lst)
            r = lst;
        else
            r = q;

        coord = ok ? r[COORD_BITS-1:0] : '0;
    end

endmodule

// ===== hdl/wbag_ctrl.sv =====
// Sequencer: maps each window offset per axis through the shared unit into tables, then scans
// the window x fastest, one cell item per cycle unless stalled. Depends on wbag_pkg, wbag_if.
module wbag_ctrl #(
    parameter int COORD_BITS = 16,
    parameter int MAX_WIN    = 4,
    parameter int WIN_BITS   = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wbag_pkg::win_cfg_t          cfg,
    input  logic [COORD_BITS-1:0]       last_x,
    input  logic [COORD_BITS-1:0]       last_y,
    input  logic [COORD_BITS-1:0]       last_z,
    wbag_anchor_if.sink                 anchors,
    wbag_cell_if.source                 cells,
    output logic [COORD_BITS-1:0]       map_anchor,
    output logic [COORD_BITS-1:0]       map_last,
    output logic [WIN_BITS-1:0]         map_k,
    output logic [WIN_BITS-1:0]         map_sub,
    output logic [wbag_pkg::MODE_W-1:0] map_mode,
    input  logic [COORD_BITS-1:0]       map_coord,
    input  logic                        map_ok
);
    localparam int IW = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;

    // Window size as used: zero reads as one, large values saturate
    function automatic logic [WIN_BITS-1:0] win_eff(input logic [wbag_pkg::WIN_W-1:0] w);
        logic [wbag_pkg::WIN_W:0] w_ext;
        w_ext = {1'b0, w};
        if (w_ext == '0)
            return WIN_BITS'(1);
        else if (w_ext > (wbag_pkg::WIN_W+1)'(MAX_WIN))
            return WIN_BITS'(MAX_WIN);
        else
            return WIN_BITS'(w_ext);
    endfunction

    wbag_pkg::state_t              state_reg, state_next;
    wbag_pkg::axis_t               axis_reg, axis_next;
    logic [WIN_BITS-1:0]           k_reg, k_next;
    logic [WIN_BITS-1:0]           cx_reg, cx_next;
    logic [WIN_BITS-1:0]           cy_reg, cy_next;
    logic [WIN_BITS-1:0]           cz_reg, cz_next;
    logic [wbag_pkg::INDEX_W-1:0]  idx_reg, idx_next;
    logic                          out_valid_reg, out_valid_next;

    logic [COORD_BITS-1:0]         ax_reg, ay_reg, az_reg;
    logic [COORD_BITS-1:0]         x_tab_reg [MAX_WIN];
    logic [COORD_BITS-1:0]         y_tab_reg [MAX_WIN];
    logic [COORD_BITS-1:0]         z_tab_reg [MAX_WIN];
    logic                          x_ok_reg  [MAX_WIN];
    logic                          y_ok_reg  [MAX_WIN];
    logic                          z_ok_reg  [MAX_WIN];

    logic [COORD_BITS-1:0]         out_x_reg, out_y_reg, out_z_reg;
    logic [wbag_pkg::INDEX_W-1:0]  out_idx_reg;
    logic                          out_ok_reg, out_last_reg;

    logic [WIN_BITS-1:0]           wx, wy, wz, cur_w;
    logic                          accept, load, map_we;
    logic                          end_x, end_y, end_z, pos_ok;

    assign wx = win_eff(cfg.win_x);
    assign wy = win_eff(cfg.win_y);
    assign wz = win_eff(cfg.win_z);

    assign accept = anchors.valid && (state_reg == wbag_pkg::ST_IDLE);
    assign map_we = (state_reg == wbag_pkg::ST_MAP);

    assign end_x  = (cx_reg == wx - WIN_BITS'(1));
    assign end_y  = (cy_reg == wy - WIN_BITS'(1));
    assign end_z  = (cz_reg == wz - WIN_BITS'(1));
    assign pos_ok = x_ok_reg[cx_reg[IW-1:0]] && y_ok_reg[cy_reg[IW-1:0]]
                 && z_ok_reg[cz_reg[IW-1:0]];

    // Operand select for the shared remap unit
    always_comb
    begin
        case (axis_reg)
            wbag_pkg::AXIS_Y:
            begin
                cur_w      = wy;
                map_anchor = ay_reg;
                map_last   = last_y;
            end
            wbag_pkg::AXIS_Z:
            begin
                cur_w      = wz;
                map_anchor = az_reg;
                map_last   = last_z;
            end
            default:
            begin
                cur_w      = wx;
                map_anchor = ax_reg;
                map_last   = last_x;
            end
        endcase
        map_k    = k_reg;
        map_sub  = cfg.centered ? (cur_w >> 1) : '0;
        map_mode = cfg.edge_mode;
    end

    // Next state and counters
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        k_next         = k_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        load           = 1'b0;

        if (out_valid_reg && cells.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            wbag_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = wbag_pkg::ST_MAP;
                    axis_next  = wbag_pkg::AXIS_X;
                    k_next     = '0;
                    cx_next    = '0;
                    cy_next    = '0;
                    cz_next    = '0;
                    idx_next   = '0;
                end
            end
            wbag_pkg::ST_MAP:
            begin
                if (k_reg == cur_w - WIN_BITS'(1))
                begin
                    k_next = '0;
                    case (axis_reg)
                        wbag_pkg::AXIS_X: axis_next = wbag_pkg::AXIS_Y;
                        wbag_pkg::AXIS_Y: axis_next = wbag_pkg::AXIS_Z;
                        wbag_pkg::AXIS_Z: state_next = wbag_pkg::ST_EMIT;
                        default:          axis_next = wbag_pkg::AXIS_X;
                    endcase
                end
                else
                begin
                    k_next = k_reg + WIN_BITS'(1);
                end
            end
            wbag_pkg::ST_EMIT:
            begin
                // Output slot free: move the next cell in
                if (!out_valid_reg || cells.ready)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + wbag_pkg::INDEX_W'(1);
                    if (end_x)
                    begin
                        cx_next = '0;
                        if (end_y)
                        begin
                            cy_next = '0;
                            if (end_z)
                                state_next = wbag_pkg::ST_IDLE;
                            else
                                cz_next = cz_reg + WIN_BITS'(1);
                        end
                        else
                        begin
                            cy_next = cy_reg + WIN_BITS'(1);
                        end
                    end
                    else
                    begin
                        cx_next = cx_reg + WIN_BITS'(1);
                    end
                end
            end
            default:
                state_next = wbag_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wbag_pkg::ST_IDLE;
            axis_reg      <= wbag_pkg::AXIS_X;
            k_reg         <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            k_reg         <= k_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            cz_reg        <= cz_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Held anchor
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= anchors.anchor_x;
            ay_reg <= anchors.anchor_y;
            az_reg <= anchors.anchor_z;
        end
    end

    // Per-axis tables of remapped coordinates
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            case (axis_reg)
                wbag_pkg::AXIS_X:
                begin
                    x_tab_reg[k_reg[IW-1:0]] <= map_coord;
                    x_ok_reg[k_reg[IW-1:0]]  <= map_ok;
                end
                wbag_pkg::AXIS_Y:
                begin
                    y_tab_reg[k_reg[IW-1:0]] <= map_coord;
                    y_ok_reg[k_reg[IW-1:0]]  <= map_ok;
                end
                wbag_pkg::AXIS_Z:
                begin
                    z_tab_reg[k_reg[IW-1:0]] <= map_coord;
                    z_ok_reg[k_reg[IW-1:0]]  <= map_ok;
                end
                default:
                begin
                    x_tab_reg[k_reg[IW-1:0]] <= map_coord;
                    x_ok_reg[k_reg[IW-1:0]]  <= map_ok;
                end
            endcase
        end
    end

    // Output register; a rejected cell reads as the origin
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_x_reg    <= pos_ok ? x_tab_reg[cx_reg[IW-1:0]] : '0;
            out_y_reg    <= pos_ok ? y_tab_reg[cy_reg[IW-1:0]] : '0;
            out_z_reg    <= pos_ok ? z_tab_reg[cz_reg[IW-1:0]] : '0;
            out_idx_reg  <= idx_reg;
            out_ok_reg   <= pos_ok;
            out_last_reg <= end_x && end_y && end_z;
        end
    end

    assign anchors.ready    = (state_reg == wbag_pkg::ST_IDLE);
    assign cells.valid      = out_valid_reg;
    assign cells.cell_x     = out_x_reg;
    assign cells.cell_y     = out_y_reg;
    assign cells.cell_z     = out_z_reg;
    assign cells.cell_index = out_idx_reg;
    assign cells.inside_res = out_ok_reg;
    assign cells.last_cell  = out_last_reg;

endmodule

// ===== hdl/window_border_address_gen.sv =====
// Top level of the window border address generator: register file, sequencer, remap unit.
// Depends on wbag_pkg, wbag_if, wbag_axis_map and wbag_ctrl.
//
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+----------------------------------------------------
//  anchors   | in  | valid / ready  | anchor_x, anchor_y, anchor_z
//  cells     | out | valid / ready  | cell_x, cell_y, cell_z, cell_index, inside_res,
//            |     |                | last_cell
//  cfg       | in  | cfg_we         | cfg_index, cfg_data (write only)
//
// An anchor is accepted in idle, then the remap unit maps one axis offset per cycle into
// the tables (x, then y, then z), then one cell leaves per cycle while the output is not
// stalled. The sequencer holds one anchor at a time; ready returns as soon as the final
// cell is in the output register. A stalled output holds its item and pauses the scan.
// Reset loads the register defaults; there is no clearing pass.
module window_border_address_gen #(
    parameter int COORD_BITS = 16,
    parameter int MAX_WIN    = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wbag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbag_pkg::CFG_DATA_W-1:0] cfg_data,
    wbag_anchor_if.sink                     anchors,
    wbag_cell_if.source                     cells
);
    localparam int WIN_BITS = $clog2(MAX_WIN + 1);

    wbag_pkg::win_cfg_t            cfg_reg;
    logic [COORD_BITS-1:0]         last_x_reg, last_y_reg, last_z_reg;

    logic [COORD_BITS-1:0]         map_anchor, map_last, map_coord;
    logic [WIN_BITS-1:0]           map_k, map_sub;
    logic [wbag_pkg::MODE_W-1:0]   map_mode;
    logic                          map_ok;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_x     <= wbag_pkg::WIN_X_RST;
            cfg_reg.win_y     <= wbag_pkg::WIN_Y_RST;
            cfg_reg.win_z     <= wbag_pkg::WIN_Z_RST;
            cfg_reg.centered  <= wbag_pkg::CENTERED_RST;
            cfg_reg.edge_mode <= wbag_pkg::MODE_RST;
            last_x_reg        <= '1;
            last_y_reg        <= '1;
            last_z_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wbag_pkg::CFG_WIN_X:    cfg_reg.win_x     <= cfg_data[wbag_pkg::WIN_W-1:0];
                wbag_pkg::CFG_WIN_Y:    cfg_reg.win_y     <= cfg_data[wbag_pkg::WIN_W-1:0];
                wbag_pkg::CFG_WIN_Z:    cfg_reg.win_z     <= cfg_data[wbag_pkg::WIN_W-1:0];
                wbag_pkg::CFG_CENTERED: cfg_reg.centered  <= cfg_data[0];
                wbag_pkg::CFG_EDGE:     cfg_reg.edge_mode <= cfg_data[wbag_pkg::MODE_W-1:0];
                wbag_pkg::CFG_LAST_X:   last_x_reg        <= COORD_BITS'(cfg_data);
                wbag_pkg::CFG_LAST_Y:   last_y_reg        <= COORD_BITS'(cfg_data);
                wbag_pkg::CFG_LAST_Z:   last_z_reg        <= COORD_BITS'(cfg_data);
                default:                last_z_reg        <= last_z_reg;
            endcase
        end
    end

    // Sequencer with tables and output register
    wbag_ctrl #(
        .COORD_BITS (COORD_BITS),
        .MAX_WIN    (MAX_WIN),
        .WIN_BITS   (WIN_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .last_x     (last_x_reg),
        .last_y     (last_y_reg),
        .last_z     (last_z_reg),
        .anchors    (anchors),
        .cells      (cells),
        .map_anchor (map_anchor),
        .map_last   (map_last),
        .map_k      (map_k),
        .map_sub    (map_sub),
        .map_mode   (map_mode),
        .map_coord  (map_coord),
        .map_ok     (map_ok)
    );

    // Shared remap unit
    wbag_axis_map #(
        .COORD_BITS (COORD_BITS),
        .WIN_BITS   (WIN_BITS)
    ) u_axis_map (
        .anchor (map_anchor),
        .last   (map_last),
        .k      (map_k),
        .sub    (map_sub),
        .mode   (map_mode),
        .coord  (map_coord),
        .ok     (map_ok)
    );

endmodule

// ===== hdl/wbag_checker.sv =====
// Port-level checks for the window border address generator, bound to the top level.
// Depends on wbag_pkg and on the top level's channel ports.
module wbag_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [COORD_BITS-1:0]        out_x,
    input logic [COORD_BITS-1:0]        out_y,
    input logic [COORD_BITS-1:0]        out_z,
    input logic [wbag_pkg::INDEX_W-1:0] out_idx,
    input logic                         out_inside,
    input logic                         out_last
);

    // Accepting an anchor starts the mapping pass
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("anchor channel ready right after an accept");

    // No new anchor while a non-final cell of the current window is on the output
    a_no_accept_mid_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("anchor channel ready before final cell");

    // Rejected cells carry the origin
    a_reject_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_inside |-> (out_x == '0) && (out_y == '0) && (out_z == '0))
        else $error("rejected cell with non-zero coordinate");

    // A stalled cell item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_idx)
            && $stable(out_last))
        else $error("stalled cell item changed");

endmodule

bind window_border_address_gen wbag_checker #(
    .COORD_BITS (COORD_BITS)
) u_wbag_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (anchors.valid),
    .in_ready   (anchors.ready),
    .out_valid  (cells.valid),
    .out_ready  (cells.ready),
    .out_x      (cells.cell_x),
    .out_y      (cells.cell_y),
    .out_z      (cells.cell_z),
    .out_idx    (cells.cell_index),
    .out_inside (cells.inside_res),
    .out_last   (cells.last_cell)
);

// ===== bench/window_border_address_gen_tb.sv =====
// Self-checking bench for window_border_address_gen: anchors go in, window cell addresses come out.
// A tracker class predicts the cells of every accepted anchor; stalls and gaps are drawn randomly.
// Depends on wbag_pkg, wbag_anchor_if / wbag_cell_if and the block itself.
module window_border_address_gen_tb;

    localparam int COORD_BITS  = 16;
    localparam int MAX_WIN     = 4;
    localparam int ITEM_TARGET = 310;
    localparam int LONG_HOLD   = 250;

    // Spare edge rule codes, expected to act as replicate
    localparam logic [wbag_pkg::MODE_W-1:0] EDGE_SPARE_LO  = 3'd5;
    localparam logic [wbag_pkg::MODE_W-1:0] EDGE_SPARE_MID = 3'd6;
    localparam logic [wbag_pkg::MODE_W-1:0] EDGE_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [COORD_BITS-1:0]        cell_x;
        logic [COORD_BITS-1:0]        cell_y;
        logic [COORD_BITS-1:0]        cell_z;
        logic [wbag_pkg::INDEX_W-1:0] cell_index;
        logic                         inside_res;
        logic                         last_cell;
    } cell_rec_t;

    // Predicts the window cells per anchor and checks them in order
    class window_cell_tracker;
        logic [wbag_pkg::WIN_W-1:0]  win_x, win_y, win_z;
        logic                        centered;
        logic [wbag_pkg::MODE_W-1:0] edge_rule;
        logic [COORD_BITS-1:0]       last_x, last_y, last_z;
        cell_rec_t                   pending_cells[$];
        int                          errors;
        int                          anchors_seen;
        int                          cells_seen;

        function new();
            win_x        = wbag_pkg::WIN_X_RST;
            win_y        = wbag_pkg::WIN_Y_RST;
            win_z        = wbag_pkg::WIN_Z_RST;
            centered     = wbag_pkg::CENTERED_RST;
            edge_rule    = wbag_pkg::MODE_RST;
            last_x       = '1;
            last_y       = '1;
            last_z       = '0;
            errors       = 0;
            anchors_seen = 0;
            cells_seen   = 0;
        endfunction

        function void set_reg(wbag_pkg::cfg_reg_t idx,
                              logic [wbag_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                wbag_pkg::CFG_WIN_X:    win_x     = data[wbag_pkg::WIN_W-1:0];
                wbag_pkg::CFG_WIN_Y:    win_y     = data[wbag_pkg::WIN_W-1:0];
                wbag_pkg::CFG_WIN_Z:    win_z     = data[wbag_pkg::WIN_W-1:0];
                wbag_pkg::CFG_CENTERED: centered  = data[0];
                wbag_pkg::CFG_EDGE:     edge_rule = data[wbag_pkg::MODE_W-1:0];
                wbag_pkg::CFG_LAST_X:   last_x    = data;
                wbag_pkg::CFG_LAST_Y:   last_y    = data;
                wbag_pkg::CFG_LAST_Z:   last_z    = data;
                default:                ;
            endcase
        endfunction

        function int pending();
            return pending_cells.size();
        endfunction

        // Size zero counts as one cell, anything above the maximum saturates
        function int span(logic [wbag_pkg::WIN_W-1:0] w);
            if (w == 0)
                return 1;
            if (w > MAX_WIN)
                return MAX_WIN;
            return int'(w);
        endfunction

        // One fold by the edge rule, then clamp; ok drops in reject mode when outside
        function longint fold(longint p, longint last, output bit ok);
            ok = 1'b1;
            case (edge_rule)
                wbag_pkg::EDGE_REFLECT:
                begin
                    if (p < 0)
                        p = -p - 1;
                    else if (p > last)
                        p = 2 * last + 1 - p;
                end
                wbag_pkg::EDGE_REFLECT_NEXT:
                begin
                    if (p < 0)
                        p = -p;
                    else if (p > last)
                        p = 2 * last - p;
                end
                wbag_pkg::EDGE_WRAP:
                begin
                    if (p < 0)
                        p = p + last + 1;
                    else if (p > last)
                        p = p - (last + 1);
                end
                wbag_pkg::EDGE_REJECT:
                begin
                    if (p < 0 || p > last)
                    begin
                        ok = 1'b0;
                        return 0;
                    end
                end
                default: ;
            endcase
            if (p < 0)
                return 0;
            if (p > last)
                return last;
            return p;
        endfunction

        // Expand one anchor into its window, x fastest, then y, then z
        function void note_anchor(logic [COORD_BITS-1:0] ax, logic [COORD_BITS-1:0] ay,
                                  logic [COORD_BITS-1:0] az);
            int        wx, wy, wz, sx, sy, sz, n;
            bit        okx, oky, okz;
            longint    rx, ry, rz;
            cell_rec_t c;
            wx = span(win_x);
            wy = span(win_y);
            wz = span(win_z);
            sx = centered ? -(wx / 2) : 0;
            sy = centered ? -(wy / 2) : 0;
            sz = centered ? -(wz / 2) : 0;
            n  = 0;
            for (int kz = 0; kz < wz; kz++)
                for (int ky = 0; ky < wy; ky++)
                    for (int kx = 0; kx < wx; kx++)
                    begin
                        rx = fold(longint'(ax) + sx + kx, longint'(last_x), okx);
                        ry = fold(longint'(ay) + sy + ky, longint'(last_y), oky);
                        rz = fold(longint'(az) + sz + kz, longint'(last_z), okz);
                        c.inside_res = okx && oky && okz;
                        if (!c.inside_res)
                        begin
                            rx = 0;
                            ry = 0;
                            rz = 0;
                        end
                        c.cell_x     = rx[COORD_BITS-1:0];
                        c.cell_y     = ry[COORD_BITS-1:0];
                        c.cell_z     = rz[COORD_BITS-1:0];
                        c.cell_index = n[wbag_pkg::INDEX_W-1:0];
                        c.last_cell  = (kx == wx - 1) && (ky == wy - 1) && (kz == wz - 1);
                        pending_cells.push_back(c);
                        n++;
                    end
            anchors_seen++;
        endfunction

        function void compare_field(string field, longint want, longint seen);
            if (want != seen)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, want, seen);
                errors++;
            end
        endfunction

        function void check_cell(cell_rec_t got);
            cell_rec_t want;
            cells_seen++;
            if (pending_cells.size() == 0)
            begin
                $error("cell item with nothing expected: x %0d y %0d z %0d index %0d",
                       got.cell_x, got.cell_y, got.cell_z, got.cell_index);
                errors++;
                return;
            end
            want = pending_cells.pop_front();
            compare_field("cell_x", want.cell_x, got.cell_x);
            compare_field("cell_y", want.cell_y, got.cell_y);
            compare_field("cell_z", want.cell_z, got.cell_z);
            compare_field("cell_index", want.cell_index, got.cell_index);
            compare_field("inside_res", want.inside_res, got.inside_res);
            compare_field("last_cell", want.last_cell, got.last_cell);
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [wbag_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [wbag_pkg::CFG_DATA_W-1:0] cfg_data;

    wbag_anchor_if #(.COORD_BITS(COORD_BITS)) anchor_ch ();
    wbag_cell_if   #(.COORD_BITS(COORD_BITS)) cell_ch ();

    window_cell_tracker board = new();

    // Stimulus knobs for the sender and the receiver, and a count of window settings
    bit tx_calm;
    bit rx_calm;
    bit hold_long;
    int window_settings;

    window_border_address_gen #(
        .COORD_BITS(COORD_BITS),
        .MAX_WIN   (MAX_WIN)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .anchors  (anchor_ch),
        .cells    (cell_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous upper bound on run time
    initial
    begin
        #15_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stall after each item, one long hold-off on request
    initial
    begin
        int        hold;
        cell_rec_t got;
        hold = 0;
        cell_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cell_ch.valid === 1'b1 && cell_ch.ready === 1'b1)
            begin
                got.cell_x     = cell_ch.cell_x;
                got.cell_y     = cell_ch.cell_y;
                got.cell_z     = cell_ch.cell_z;
                got.cell_index = cell_ch.cell_index;
                got.inside_res = cell_ch.inside_res;
                got.last_cell  = cell_ch.last_cell;
                board.check_cell(got);
                hold = rx_calm ? 0 : $urandom_range(0, 13);
            end
            if (hold_long)
            begin
                hold      = LONG_HOLD;
                hold_long = 1'b0;
            end
            if (hold > 0)
            begin
                cell_ch.ready <= 1'b0;
                hold--;
            end
            else
                cell_ch.ready <= 1'b1;
        end
    end

    task automatic wait_empty();
        while (board.pending() > 0)
            @(posedge clk);
    endtask

    // Close a phase: stop offering, let every cell drain, leave the block idle
    task automatic settle_block();
        anchor_ch.valid <= 1'b0;
        wait_empty();
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(wbag_pkg::cfg_reg_t idx, logic [wbag_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.set_reg(idx, data);
        @(posedge clk);
    endtask

    // Write all eight registers; narrow ones carry random junk in the upper bits
    task automatic load_window(logic [wbag_pkg::WIN_W-1:0] wx, logic [wbag_pkg::WIN_W-1:0] wy,
                               logic [wbag_pkg::WIN_W-1:0] wz, logic cen,
                               logic [wbag_pkg::MODE_W-1:0] mode,
                               logic [wbag_pkg::CFG_DATA_W-1:0] lx,
                               logic [wbag_pkg::CFG_DATA_W-1:0] ly,
                               logic [wbag_pkg::CFG_DATA_W-1:0] lz);
        int unsigned junk;
        junk = $urandom;
        put_reg(wbag_pkg::CFG_WIN_X, {junk[wbag_pkg::CFG_DATA_W-1:wbag_pkg::WIN_W], wx});
        junk = $urandom;
        put_reg(wbag_pkg::CFG_WIN_Y, {junk[wbag_pkg::CFG_DATA_W-1:wbag_pkg::WIN_W], wy});
        junk = $urandom;
        put_reg(wbag_pkg::CFG_WIN_Z, {junk[wbag_pkg::CFG_DATA_W-1:wbag_pkg::WIN_W], wz});
        junk = $urandom;
        put_reg(wbag_pkg::CFG_CENTERED, {junk[wbag_pkg::CFG_DATA_W-1:1], cen});
        junk = $urandom;
        put_reg(wbag_pkg::CFG_EDGE, {junk[wbag_pkg::CFG_DATA_W-1:wbag_pkg::MODE_W], mode});
        put_reg(wbag_pkg::CFG_LAST_X, lx);
        put_reg(wbag_pkg::CFG_LAST_Y, ly);
        put_reg(wbag_pkg::CFG_LAST_Z, lz);
        cfg_we <= 1'b0;
        window_settings++;
    endtask

    // Offer one anchor after a random gap; optionally wait for all cells first
    task automatic send_anchor(logic [COORD_BITS-1:0] ax, logic [COORD_BITS-1:0] ay,
                               logic [COORD_BITS-1:0] az, bit drain_first = 1'b0);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (drain_first && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            anchor_ch.valid <= 1'b0;
            if (drain_first)
                wait_empty();
            repeat (gap) @(posedge clk);
        end
        anchor_ch.valid    <= 1'b1;
        anchor_ch.anchor_x <= ax;
        anchor_ch.anchor_y <= ay;
        anchor_ch.anchor_z <= az;
        do
            @(posedge clk);
        while (anchor_ch.ready !== 1'b1);
        board.note_anchor(ax, ay, az);
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord(logic [COORD_BITS-1:0] last);
        int unsigned v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 4);
            1:       v = 32'(last) - 32'd2 + $urandom_range(0, 4);
            default: v = $urandom;
        endcase
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic [wbag_pkg::CFG_DATA_W-1:0] pick_last();
        int unsigned v;
        case ($urandom_range(0, 4))
            0:       v = $urandom_range(0, 3);
            1:       v = $urandom_range(4, 40);
            2:       v = $urandom;
            3:       v = 32'hFFFF_FFFF;
            default: v = $urandom_range(0, 300);
        endcase
        return v[wbag_pkg::CFG_DATA_W-1:0];
    endfunction

    // Mostly small windows, now and then the full code range including zero and oversize
    function automatic logic [wbag_pkg::WIN_W-1:0] pick_win();
        int unsigned v;
        if ($urandom_range(0, 3) == 0)
            v = $urandom_range(0, 7);
        else
            v = $urandom_range(1, 3);
        return v[wbag_pkg::WIN_W-1:0];
    endfunction

    // Main sequence
    initial
    begin
        int          phase;
        int          n_items;
        int unsigned draw_cen;
        int unsigned draw_mode;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= wbag_pkg::CFG_WIN_X;
        cfg_data           <= '0;
        anchor_ch.valid    <= 1'b0;
        anchor_ch.anchor_x <= '0;
        anchor_ch.anchor_y <= '0;
        anchor_ch.anchor_z <= '0;
        tx_calm         = 1'b0;
        rx_calm         = 1'b0;
        hold_long       = 1'b0;
        window_settings = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: centered 3x3x1 replicate, flat z raster
        send_anchor(16'd0, 16'd0, 16'd0);
        send_anchor(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_anchor(16'd1, 16'd1, 16'd5);
        settle_block();

        // Largest window at the corner, reflect on a tiny raster, fold not enough
        load_window(3'd4, 3'd4, 3'd4, 1'b0, wbag_pkg::EDGE_REFLECT, 16'd5, 16'd5, 16'd5);
        send_anchor(16'd0, 16'd0, 16'd0);
        send_anchor(16'd5, 16'd5, 16'd5);
        send_anchor(16'hFFFF, 16'd0, 16'd3);
        settle_block();

        // Zero and oversize window codes, reflect without edge, single row raster
        load_window(3'd0, 3'd7, 3'd5, 1'b1, wbag_pkg::EDGE_REFLECT_NEXT,
                    16'd0, 16'd1, 16'hFFFF);
        send_anchor(16'd0, 16'd0, 16'd0);
        send_anchor(16'd1, 16'd1, 16'd1);
        send_anchor(16'd3, 16'd0, 16'hFFFF);
        settle_block();

        // Wrap around both ends, far out of range anchors
        load_window(3'd2, 3'd1, 3'd3, 1'b1, wbag_pkg::EDGE_WRAP, 16'd3, 16'hFFFF, 16'd2);
        send_anchor(16'd0, 16'd0, 16'd0);
        send_anchor(16'd3, 16'hFFFF, 16'd2);
        send_anchor(16'hFFFF, 16'd100, 16'd0);
        send_anchor(16'd9, 16'd9, 16'd9);
        settle_block();

        // Reject mode: cells outside on some axis come back flagged and zeroed
        load_window(3'd4, 3'd4, 3'd1, 1'b1, wbag_pkg::EDGE_REJECT, 16'd10, 16'd10, 16'd0);
        send_anchor(16'd0, 16'd0, 16'd0);
        send_anchor(16'd10, 16'd10, 16'd0);
        send_anchor(16'd5, 16'd5, 16'd0);
        send_anchor(16'd11, 16'd3, 16'd0);
        settle_block();

        // Spare edge codes behave as replicate
        load_window(3'd3, 3'd2, 3'd2, 1'b0, EDGE_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_anchor(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_anchor(16'd0, 16'd0, 16'd0);
        settle_block();
        load_window(3'd1, 3'd1, 3'd1, 1'b1, EDGE_SPARE_HI, 16'd0, 16'd0, 16'd0);
        send_anchor(16'd7, 16'd0, 16'd0);
        send_anchor(16'd0, 16'd0, 16'd0);
        settle_block();
        load_window(3'd2, 3'd2, 3'd2, 1'b1, EDGE_SPARE_MID, 16'd1, 16'd1, 16'd1);
        send_anchor(16'd1, 16'd1, 16'd1);
        send_anchor(16'd2, 16'd2, 16'd2);
        settle_block();

        // Random phases, each with a fresh window setting
        phase = 0;
        while (board.anchors_seen < ITEM_TARGET)
        begin
            tx_calm   = (phase % 4 == 1) || (phase == 2);
            rx_calm   = (phase % 4 == 1);
            draw_cen  = $urandom_range(0, 1);
            draw_mode = $urandom_range(EDGE_SPARE_HI, wbag_pkg::EDGE_REPLICATE);
            load_window(pick_win(), pick_win(), pick_win(), draw_cen[0],
                        draw_mode[wbag_pkg::MODE_W-1:0],
                        pick_last(), pick_last(), pick_last());
            // long output hold-off while anchors keep coming
            if (phase == 2)
                hold_long = 1'b1;
            n_items = $urandom_range(12, 24);
            for (int i = 0; i < n_items; i++)
                send_anchor(pick_coord(board.last_x), pick_coord(board.last_y),
                            pick_coord(board.last_z), (phase == 4) && (i == n_items / 2));
            settle_block();
            phase++;
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        wait_empty();
        repeat (20) @(posedge clk);
        $display("Run covered %0d anchors over %0d window settings, %0d cells compared.",
                 board.anchors_seen, window_settings, board.cells_seen);
        $display("Edge rules, spare codes, zero and oversize windows and reject mode exercised.");
        if (board.errors == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
        begin
            if (board.pending() != 0)
                $error("%0d expected cells never arrived", board.pending());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
